>>> rtl/lru_pr_pkg.sv
// Shared types and constants for the LRU page replacement block.
package lru_pr_pkg;

    localparam int CFG_W   = 6;
    localparam int FRAME_W = 5;
    localparam int FAULT_W = 16;

    localparam logic [CFG_W-1:0]   CFG_RESET = 6'd3;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic look;
        logic commit;
        logic is_hit;
        logic any_empty;
    } cell_ctl_t;

    // priority chain handed from cell to cell, lowest index first
    typedef struct packed {
        logic hit_seen;
        logic empty_seen;
        logic vict_seen;
    } cell_chain_t;

endpackage

>>> rtl/lru_pr_cell.sv
// One page frame: stored page, valid bit, recency rank and priority chain stage.
module lru_pr_cell import lru_pr_pkg::*; #(
    parameter int MAX_FRAMES = 32,
    parameter int PAGE_BITS  = 8,
    localparam int RANK_W    = $clog2(MAX_FRAMES)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_range,
    input  logic [PAGE_BITS-1:0] page,
    input  logic                 vict_cand,
    input  cell_ctl_t            ctl,
    input  logic [RANK_W-1:0]    hit_rank,
    input  cell_chain_t          chain_in,
    output cell_chain_t          chain_out,
    output logic                 sel,
    output logic                 hit_sel,
    output logic [RANK_W-1:0]    rank,
    output logic [PAGE_BITS-1:0] stored_page
);

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_FRAMES - 1);

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic [RANK_W-1:0]    rank_reg;
    logic                 hit_flag_reg;
    logic                 empty_flag_reg;
    logic                 cand_reg;
    logic                 empty_sel;
    logic                 vict_sel;
    logic                 ages;

    assign hit_sel   = hit_flag_reg & ~chain_in.hit_seen;
    assign empty_sel = empty_flag_reg & ~chain_in.empty_seen;
    assign vict_sel  = cand_reg & ~chain_in.vict_seen;

    assign chain_out.hit_seen   = chain_in.hit_seen | hit_flag_reg;
    assign chain_out.empty_seen = chain_in.empty_seen | empty_flag_reg;
    assign chain_out.vict_seen  = chain_in.vict_seen | cand_reg;

    always_comb begin
        if (ctl.is_hit) begin
            sel = hit_sel;
        end else if (ctl.any_empty) begin
            sel = empty_sel;
        end else begin
            sel = vict_sel;
        end
    end

    assign ages = in_range & valid_reg & (rank_reg != RANK_MAX)
                & (~ctl.is_hit | (rank_reg < hit_rank));

    assign rank        = rank_reg;
    assign stored_page = page_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            rank_reg       <= '0;
            hit_flag_reg   <= 1'b0;
            empty_flag_reg <= 1'b0;
            cand_reg       <= 1'b0;
        end else begin
            if (ctl.look) begin
                hit_flag_reg   <= in_range & valid_reg & (page_reg == page);
                empty_flag_reg <= in_range & ~valid_reg;
                cand_reg       <= vict_cand;
            end
            if (ctl.commit) begin
                if (sel) begin
                    rank_reg <= '0;
                    if (!ctl.is_hit) begin
                        valid_reg <= 1'b1;
                    end
                end else if (ages) begin
                    rank_reg <= rank_reg + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.commit && sel && !ctl.is_hit) begin
            page_reg <= page;
        end
    end

endmodule

>>> rtl/lru_page_replacement_top.sv
// LRU page replacement: a row of frame cells with a two-step lookup/update controller.
// A reference accepted in ST_IDLE passes ST_LOOK, then ST_UPD; m_valid rises once ST_UPD commits to a free output.
// Each reference takes a lookup step, then an update step of the cell row.
// The next reference is taken in the update cycle while the output register is free to load.
// Reset (synchronous, aresetn low): all frames empty, ranks and fault count zero,
// frames_in_use back to 3; no clearing pass is needed.
module lru_page_replacement_top import lru_pr_pkg::*; #(
    parameter int MAX_FRAMES = 32,
    parameter int PAGE_BITS  = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PAGE_BITS-1:0] s_virtual_page,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit,
    output logic [FRAME_W-1:0]   m_frame_used,
    output logic                 m_evicted_valid,
    output logic [PAGE_BITS-1:0] m_evicted_page,
    output logic [FAULT_W-1:0]   m_fault_count
);

    localparam int RANK_W = $clog2(MAX_FRAMES);
    localparam int IDX_W  = $clog2(MAX_FRAMES);
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     frames_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [FAULT_W-1:0]   faults_reg;
    logic                 m_valid_reg;
    logic                 m_hit_reg;
    logic [IDX_W-1:0]     m_slot_reg;
    logic                 m_ev_valid_reg;
    logic [PAGE_BITS-1:0] m_ev_page_reg;

    logic [CNT_W-1:0]      n_eff;
    logic [MAX_FRAMES-1:0] in_range;
    logic [MAX_FRAMES-1:0] elim_cand;
    logic [MAX_FRAMES-1:0] elim_bits;
    logic [MAX_FRAMES-1:0] cell_sel;
    logic [MAX_FRAMES-1:0] cell_hit_sel;
    logic [RANK_W-1:0]     cell_rank [MAX_FRAMES];
    logic [PAGE_BITS-1:0]  cell_page [MAX_FRAMES];
    cell_chain_t           chain [MAX_FRAMES+1];
    cell_ctl_t             ctl;

    logic                 s_fire;
    logic                 out_free;
    logic                 is_hit;
    logic                 any_empty;
    logic [RANK_W-1:0]    hit_rank;
    logic [IDX_W-1:0]     slot;
    logic [PAGE_BITS-1:0] ev_page;

    assign cfg_ready = 1'b1;

    always_comb begin
        if (frames_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (int'(frames_reg) > MAX_FRAMES) begin
            n_eff = CNT_W'(MAX_FRAMES);
        end else begin
            n_eff = CNT_W'(frames_reg);
        end
        for (int i = 0; i < MAX_FRAMES; i++) begin
            in_range[i] = (i < int'(n_eff));
        end
    end

    // MSB-first elimination leaves the frames holding the largest rank
    always_comb begin
        elim_cand = in_range;
        elim_bits = '0;
        for (int b = RANK_W - 1; b >= 0; b--) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                elim_bits[i] = cell_rank[i][b];
            end
            if (|(elim_cand & elim_bits)) begin
                elim_cand = elim_cand & elim_bits;
            end
        end
    end

    assign chain[0]  = '0;
    assign is_hit    = chain[MAX_FRAMES].hit_seen;
    assign any_empty = chain[MAX_FRAMES].empty_seen;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        lru_pr_cell #(
            .MAX_FRAMES (MAX_FRAMES),
            .PAGE_BITS  (PAGE_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .in_range    (in_range[g]),
            .page        (page_reg),
            .vict_cand   (elim_cand[g]),
            .ctl         (ctl),
            .hit_rank    (hit_rank),
            .chain_in    (chain[g]),
            .chain_out   (chain[g+1]),
            .sel         (cell_sel[g]),
            .hit_sel     (cell_hit_sel[g]),
            .rank        (cell_rank[g]),
            .stored_page (cell_page[g])
        );
    end

    always_comb begin
        hit_rank = '0;
        slot     = '0;
        ev_page  = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (cell_hit_sel[i]) begin
                hit_rank = hit_rank | cell_rank[i];
            end
            if (cell_sel[i]) begin
                slot    = slot | IDX_W'(i);
                ev_page = ev_page | cell_page[i];
            end
        end
    end

    assign out_free = ~m_valid_reg | m_ready;
    assign s_fire   = s_valid & s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) begin
                    state_next = s_fire ? ST_LOOK : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        ctl.look      = 1'b0;
        ctl.commit    = 1'b0;
        ctl.is_hit    = is_hit;
        ctl.any_empty = any_empty;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_LOOK: begin
                ctl.look = 1'b1;
            end
            ST_UPD: begin
                s_ready    = out_free;
                ctl.commit = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            frames_reg  <= CFG_RESET;
            faults_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                frames_reg <= cfg_data;
            end
            if (ctl.commit) begin
                m_valid_reg <= 1'b1;
                if (!is_hit && faults_reg != FAULT_MAX) begin
                    faults_reg <= faults_reg + FAULT_W'(1);
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            page_reg <= s_virtual_page;
        end
        if (ctl.commit) begin
            m_hit_reg      <= is_hit;
            m_slot_reg     <= slot;
            m_ev_valid_reg <= ~is_hit & ~any_empty;
            m_ev_page_reg  <= (~is_hit & ~any_empty) ? ev_page : '0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_frame_used    = FRAME_W'(m_slot_reg);
    assign m_evicted_valid = m_ev_valid_reg;
    assign m_evicted_page  = m_ev_page_reg;
    assign m_fault_count   = faults_reg;

endmodule

>>> rtl/lru_pr_checker.sv
// Port-level checks for the LRU page replacement block, bound to its top level.
module lru_pr_checker import lru_pr_pkg::*; #(
    parameter int PAGE_BITS = 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_hit,
    input logic [FRAME_W-1:0]   m_frame_used,
    input logic                 m_evicted_valid,
    input logic [PAGE_BITS-1:0] m_evicted_page,
    input logic [FAULT_W-1:0]   m_fault_count
);

    logic [FAULT_W-1:0] last_fault_reg;
    logic               m_fire;

    assign m_fire = m_valid & m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_fault_reg <= '0;
        end else if (m_fire) begin
            last_fault_reg <= m_fault_count;
        end
    end

    a_evict_is_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted_valid |-> !m_hit)
        else $error("eviction reported on a hit");

    a_no_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted_valid |-> m_evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    a_fault_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire |-> (m_hit && m_fault_count == last_fault_reg)
                || (!m_hit && m_fault_count == last_fault_reg + FAULT_W'(1))
                || (!m_hit && m_fault_count == FAULT_MAX && last_fault_reg == FAULT_MAX))
        else $error("fault count step mismatch");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_used) && $stable(m_fault_count)
                                && $stable(m_hit) && $stable(m_evicted_page))
        else $error("result word changed while stalled");

endmodule

bind lru_page_replacement_top lru_pr_checker #(
    .PAGE_BITS (PAGE_BITS)
) u_lru_pr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_hit           (m_hit),
    .m_frame_used    (m_frame_used),
    .m_evicted_valid (m_evicted_valid),
    .m_evicted_page  (m_evicted_page),
    .m_fault_count   (m_fault_count)
);

>>> verif/tb_lru_page_replacement_top.sv
// Self-checking testbench for lru_page_replacement_top: directed table and random traces.
module tb_lru_page_replacement_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lru_pr_pkg::*;

    localparam int MAX_FRAMES  = 32;
    localparam int PAGE_BITS   = 8;
    localparam int N_DIR       = 20;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_WORDS = 75;
    localparam int LAT_CYCLES  = 4;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic                 hit;
        logic [FRAME_W-1:0]   frame;
        logic                 evicted;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [FAULT_W-1:0]   faults;
    } page_result_t;

    typedef struct {
        bit                   load_cfg;
        logic [CFG_W-1:0]     cfg;
        logic [PAGE_BITS-1:0] page;
        bit                   typed;
        page_result_t         want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [PAGE_BITS-1:0] s_virtual_page;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_hit;
    logic [FRAME_W-1:0]   m_frame_used;
    logic                 m_evicted_valid;
    logic [PAGE_BITS-1:0] m_evicted_page;
    logic [FAULT_W-1:0]   m_fault_count;

    // shadow of the frame table
    logic [PAGE_BITS-1:0] pg_tab [MAX_FRAMES];
    bit                   pg_live [MAX_FRAMES];
    logic [FRAME_W-1:0]   age_rank [MAX_FRAMES];
    logic [FAULT_W-1:0]   fault_tally;
    logic [CFG_W-1:0]     frames_cfg;

    page_result_t pending_results [$];
    dir_row_t     dir_tab [N_DIR];
    int           err_count;
    int           burst_left;

    lru_page_replacement_top #(
        .MAX_FRAMES(MAX_FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_virtual_page (s_virtual_page),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_frame_used   (m_frame_used),
        .m_evicted_valid(m_evicted_valid),
        .m_evicted_page (m_evicted_page),
        .m_fault_count  (m_fault_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int eff_frames();
        if (frames_cfg == '0) return 1;
        if (frames_cfg > MAX_FRAMES) return MAX_FRAMES;
        return int'(frames_cfg);
    endfunction

    function automatic void age_frame(input int idx);
        if (age_rank[idx] < MAX_FRAMES - 1) age_rank[idx] += 1'b1;
    endfunction

    function automatic page_result_t predict_reference(input logic [PAGE_BITS-1:0] page);
        int                 n;
        int                 slot;
        bit                 found;
        bit                 empty;
        logic [FRAME_W-1:0] r;
        logic [FRAME_W-1:0] best;
        page_result_t       res;
        n     = eff_frames();
        slot  = 0;
        found = 1'b0;
        empty = 1'b0;
        res   = '0;
        for (int i = 0; i < n && !found; i++) begin
            if (pg_live[i] && pg_tab[i] == page) begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (found) begin
            r       = age_rank[slot];
            res.hit = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (i != slot && pg_live[i] && age_rank[i] < r) age_frame(i);
            end
        end else begin
            for (int i = 0; i < n && !empty; i++) begin
                if (!pg_live[i]) begin
                    slot  = i;
                    empty = 1'b1;
                end
            end
            if (!empty) begin
                best = '0;
                slot = 0;
                for (int i = 0; i < n; i++) begin
                    if (age_rank[i] > best) begin
                        best = age_rank[i];
                        slot = i;
                    end
                end
                res.evicted      = 1'b1;
                res.evicted_page = pg_tab[slot];
            end
            for (int i = 0; i < n; i++) begin
                if (i != slot && pg_live[i]) age_frame(i);
            end
            pg_tab[slot]  = page;
            pg_live[slot] = 1'b1;
            if (fault_tally != FAULT_MAX) fault_tally += 1'b1;
        end
        age_rank[slot] = '0;
        res.frame      = slot[FRAME_W-1:0];
        res.faults     = fault_tally;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_CAP) $display("ERROR %0t ns: %s", $realtime, msg);
    endtask

    task automatic check_result();
        page_result_t exp_r;
        if (pending_results.size() == 0) begin
            report_mismatch("result word with nothing pending");
        end else begin
            exp_r = pending_results.pop_front();
            if (m_hit !== exp_r.hit)
                report_mismatch($sformatf("hit: got %0d want %0d", m_hit, exp_r.hit));
            if (m_frame_used !== exp_r.frame)
                report_mismatch($sformatf("frame_used: got %0d want %0d",
                                          m_frame_used, exp_r.frame));
            if (m_evicted_valid !== exp_r.evicted)
                report_mismatch($sformatf("evicted_valid: got %0d want %0d",
                                          m_evicted_valid, exp_r.evicted));
            if (m_evicted_page !== exp_r.evicted_page)
                report_mismatch($sformatf("evicted_page: got %0h want %0h",
                                          m_evicted_page, exp_r.evicted_page));
            if (m_fault_count !== exp_r.faults)
                report_mismatch($sformatf("fault_count: got %0d want %0d",
                                          m_fault_count, exp_r.faults));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) check_result();
    end

    // result side back-pressure
    initial begin
        int          tick;
        int          mode;
        logic [15:0] pat;
        tick    = 0;
        mode    = 0;
        pat     = '1;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (tick % 48 == 0) begin
                mode = $urandom_range(0, 3);
                pat  = 16'($urandom);
            end
            if (mode == 0) begin
                m_ready <= 1'b1;
            end else if (mode == 1) begin
                m_ready <= pat[tick % 16];
            end else if (mode == 2) begin
                m_ready <= (tick % 5 == 0);
            end else begin
                m_ready <= ~pat[tick % 16] | pat[(tick + 3) % 16];
            end
        end
    end

    task automatic send_page(input logic [PAGE_BITS-1:0] page, input bit typed,
                             input page_result_t want);
        int           gap;
        page_result_t pred;
        gap = 0;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 10);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_virtual_page <= page;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pred = predict_reference(page);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LAT_CYCLES) @(posedge aclk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        frames_cfg = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int                   pool;
        int                   base;
        logic [PAGE_BITS-1:0] pg;
        logic [CFG_W-1:0]     cfg_pick;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_virtual_page = '0;
        burst_left     = 0;
        err_count      = 0;
        fault_tally    = '0;
        frames_cfg     = CFG_RESET;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            pg_tab[i]   = '0;
            pg_live[i]  = 1'b0;
            age_rank[i] = '0;
        end

        dir_tab = '{
            '{1'b0, 6'd0,  8'h00, 1'b1, '{1'b0, 5'd0, 1'b0, 8'h00, 16'd1}},
            '{1'b0, 6'd0,  8'hFF, 1'b1, '{1'b0, 5'd1, 1'b0, 8'h00, 16'd2}},
            '{1'b0, 6'd0,  8'h00, 1'b1, '{1'b1, 5'd0, 1'b0, 8'h00, 16'd2}},
            '{1'b0, 6'd0,  8'h5A, 1'b1, '{1'b0, 5'd2, 1'b0, 8'h00, 16'd3}},
            '{1'b0, 6'd0,  8'hA5, 1'b1, '{1'b0, 5'd1, 1'b1, 8'hFF, 16'd4}},
            '{1'b0, 6'd0,  8'hFF, 1'b0, '0},
            '{1'b1, 6'd0,  8'hFF, 1'b0, '0},   // zero frames acts as one
            '{1'b0, 6'd0,  8'h02, 1'b0, '0},
            '{1'b0, 6'd0,  8'hA5, 1'b0, '0},   // parked in a frame now out of use
            '{1'b1, 6'd3,  8'hA5, 1'b0, '0},   // resident twice, lowest frame hits
            '{1'b0, 6'd0,  8'h5A, 1'b0, '0},
            '{1'b1, 6'd63, 8'h77, 1'b0, '0},   // clamps to max frames
            '{1'b0, 6'd0,  8'h78, 1'b0, '0},
            '{1'b0, 6'd0,  8'h79, 1'b0, '0},
            '{1'b1, 6'd32, 8'hA5, 1'b0, '0},
            '{1'b1, 6'd1,  8'h00, 1'b0, '0},
            '{1'b0, 6'd0,  8'h00, 1'b0, '0},
            '{1'b1, 6'd40, 8'hFF, 1'b0, '0},
            '{1'b0, 6'd0,  8'h80, 1'b0, '0},
            '{1'b0, 6'd0,  8'h7F, 1'b0, '0}
        };

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].load_cfg) write_frames(dir_tab[k].cfg);
            send_page(dir_tab[k].page, dir_tab[k].typed, dir_tab[k].want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: cfg_pick = 6'd32;
                1: cfg_pick = 6'd1;
                2: cfg_pick = 6'd0;
                3: cfg_pick = 6'd63;
                4: cfg_pick = 6'd2;
                default: begin
                    if ($urandom_range(0, 1) == 1) cfg_pick = CFG_W'($urandom_range(1, 8));
                    else cfg_pick = CFG_W'($urandom_range(0, 63));
                end
            endcase
            write_frames(cfg_pick);
            // page pool a bit larger than the frame count keeps hits and evictions mixed
            pool = eff_frames() + eff_frames() / 2 + 1;
            base = $urandom_range(0, 256 - pool);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (ph == 5 && k == PHASE_WORDS / 2) drain_results();
                if ($urandom_range(0, 99) < 85)
                    pg = PAGE_BITS'(base + $urandom_range(0, pool - 1));
                else pg = PAGE_BITS'($urandom_range(0, 255));
                send_page(pg, 1'b0, '0);
            end
        end

        drain_results();

        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
